### design/bba_pkg.sv
// Shared types and constants for the bitmap block allocator.
`default_nettype none

package bba_pkg;

  // Operation codes
  localparam logic [1:0] OP_ALLOC     = 2'd0;
  localparam logic [1:0] OP_MARK_USED = 2'd1;
  localparam logic [1:0] OP_MARK_FREE = 2'd2;
  localparam logic [1:0] OP_QUERY     = 2'd3;

  // Configuration register indexes
  localparam int unsigned CFG_IDX_W = 1;
  localparam logic [CFG_IDX_W-1:0] REG_BLOCK_COUNT = 1'd0;
  localparam logic [CFG_IDX_W-1:0] REG_BASE_BLOCK  = 1'd1;

  // Field widths
  localparam int unsigned OP_W    = 2;
  localparam int unsigned IDX_W   = 10;
  localparam int unsigned COUNT_W = 11;
  localparam int unsigned BASE_W  = 16;
  localparam int unsigned BLK_W   = 17;
  localparam int unsigned CFG_W   = 16;

  // Bitmap word geometry
  localparam int unsigned WORD_W  = 32;
  localparam int unsigned BIT_W   = 5;

  // Controller to datapath commands
  typedef struct packed {
    logic clr_wr;     // clear one bitmap word, step the address
    logic load;       // capture an input beat
    logic scan_rd;    // read the next word of the allocation scan
    logic idx_rd;     // read the word that holds the requested index
    logic alloc_fin;  // finish an allocation from the word just read
    logic mark_fin;   // finish a mark or query from the word just read
    logic fail;       // finish with ok cleared and nothing changed
    logic out_load;   // move the result into the output register
  } cmd_t;

  // Datapath to controller status
  typedef struct packed {
    logic clr_last;   // clearing pass is at the last word
    logic in_range;   // captured index is below the block count
    logic words_zero; // block count is zero
    logic found;      // word under test holds a free block
    logic last_word;  // word under test is the last one in range
    logic out_free;   // output register can take a result this cycle
  } sts_t;

endpackage

`default_nettype wire

### design/bba_ctrl.sv
// Sequencing state machine for the bitmap block allocator.
`default_nettype none

module bba_ctrl (
  input  wire logic         clk,
  input  wire logic         rst_n,
  input  wire logic         in_valid,
  input  wire logic [1:0]   in_op,
  output logic              in_ready,
  input  bba_pkg::sts_t     sts,
  output bba_pkg::cmd_t     cmd
);
  import bba_pkg::*;

  localparam logic [2:0] S_CLEAR = 3'd0;
  localparam logic [2:0] S_IDLE  = 3'd1;
  localparam logic [2:0] S_SCAN0 = 3'd2;
  localparam logic [2:0] S_SCAN  = 3'd3;
  localparam logic [2:0] S_RD    = 3'd4;
  localparam logic [2:0] S_MOD   = 3'd5;
  localparam logic [2:0] S_DONE  = 3'd6;

  logic [2:0] state_r;
  logic [2:0] state_nxt;

  assign in_ready = (state_r == S_IDLE);

  // Next state and command decode
  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    case (state_r)
      S_CLEAR: begin
        cmd.clr_wr = 1'b1;
        if (sts.clr_last) begin
          state_nxt = S_IDLE;
        end
      end
      S_IDLE: begin
        if (in_valid) begin
          cmd.load  = 1'b1;
          state_nxt = (in_op == OP_ALLOC) ? S_SCAN0 : S_RD;
        end
      end
      S_SCAN0: begin
        if (sts.words_zero) begin
          cmd.fail  = 1'b1;
          state_nxt = S_DONE;
        end else begin
          cmd.scan_rd = 1'b1;
          state_nxt   = S_SCAN;
        end
      end
      S_SCAN: begin
        if (sts.found || sts.last_word) begin
          cmd.alloc_fin = 1'b1;
          state_nxt     = S_DONE;
        end else begin
          cmd.scan_rd = 1'b1;
        end
      end
      S_RD: begin
        if (!sts.in_range) begin
          cmd.fail  = 1'b1;
          state_nxt = S_DONE;
        end else begin
          cmd.idx_rd = 1'b1;
          state_nxt  = S_MOD;
        end
      end
      S_MOD: begin
        cmd.mark_fin = 1'b1;
        state_nxt    = S_DONE;
      end
      S_DONE: begin
        if (sts.out_free) begin
          cmd.out_load = 1'b1;
          state_nxt    = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // State register; reset starts the clearing pass
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_CLEAR;
    end else begin
      state_r <= state_nxt;
    end
  end

endmodule

`default_nettype wire

### design/bba_dpath.sv
// Bitmap memory, free counter, config registers and result registers.
`default_nettype none

module bba_dpath #(
  parameter int unsigned MAX_BLOCKS = 1024
) (
  input  wire logic                           clk,
  input  wire logic                           rst_n,
  input  wire logic [bba_pkg::OP_W-1:0]       in_op,
  input  wire logic [bba_pkg::IDX_W-1:0]      in_block_index,
  input  wire logic                           cfg_valid,
  input  wire logic [bba_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [bba_pkg::CFG_W-1:0]      cfg_data,
  output logic                                out_valid,
  input  wire logic                           out_ready,
  output logic                                out_ok,
  output logic [bba_pkg::BLK_W-1:0]           out_allocated_block,
  output logic [bba_pkg::COUNT_W-1:0]         out_free_blocks,
  input  bba_pkg::cmd_t                       cmd,
  output bba_pkg::sts_t                       sts
);
  import bba_pkg::*;

  localparam int unsigned WORDS = (MAX_BLOCKS + WORD_W - 1) / WORD_W;
  localparam int unsigned AW    = (WORDS > 1) ? $clog2(WORDS) : 1;
  localparam logic [16:0] MAX_EXT  = 17'(MAX_BLOCKS);
  localparam logic [COUNT_W-1:0] FREE_RST =
    (MAX_BLOCKS < 1024) ? COUNT_W'(MAX_BLOCKS) : COUNT_W'(1024);
  localparam logic [AW-1:0] LAST_ADDR = AW'(WORDS - 1);

  // Bitmap storage, one bit per block, 1 = used
  logic [WORD_W-1:0] mem [WORDS];
  logic [WORD_W-1:0] rdata_r;

  logic [OP_W-1:0]    op_r;
  logic [IDX_W-1:0]   idx_r;
  logic [AW-1:0]      addr_r;
  logic [AW-1:0]      eval_addr_r;
  logic [COUNT_W-1:0] blk_count_r;
  logic [BASE_W-1:0]  base_r;
  logic [COUNT_W-1:0] free_r;
  logic [COUNT_W-1:0] free_nxt;
  logic               res_ok_r;
  logic [BLK_W-1:0]   res_alloc_r;
  logic               out_valid_r;
  logic               out_ok_r;
  logic [BLK_W-1:0]   out_alloc_r;
  logic [COUNT_W-1:0] out_free_r;

  logic [COUNT_W-1:0] limit;
  logic [6:0]         nwords;
  logic [11:0]        limit_up;
  logic [16:0]        idx_wide;
  logic [AW-1:0]      idx_word;
  logic [WORD_W-1:0]  idx_bit;
  logic [16:0]        word_base;
  logic [16:0]        rem;
  logic [WORD_W-1:0]  valid_mask;
  logic [WORD_W-1:0]  free_vec;
  logic [BIT_W-1:0]   pos;
  logic               found;
  logic               dec;
  logic               inc;
  logic               we;
  logic [AW-1:0]      waddr;
  logic [WORD_W-1:0]  wdata;
  logic               re;
  logic [AW-1:0]      raddr;

  // Block count clamped to the bitmap size
  assign limit    = ({6'd0, blk_count_r} > MAX_EXT) ? MAX_EXT[COUNT_W-1:0] : blk_count_r;
  assign limit_up = {1'b0, limit} + 12'd31;
  assign nwords   = limit_up[11:5];

  // Word and bit of the captured index
  assign idx_wide = {7'd0, idx_r};
  assign idx_word = idx_wide[AW+4:5];
  assign idx_bit  = WORD_W'(1) << idx_r[BIT_W-1:0];

  // Free bits of the word under test, bits past the count masked off
  assign word_base  = 17'({eval_addr_r, 5'd0});
  assign rem        = {6'd0, limit} - word_base;
  assign valid_mask = (rem >= 17'd32) ? '1 : ((WORD_W'(1) << rem[4:0]) - WORD_W'(1));
  assign free_vec   = ~rdata_r & valid_mask;
  assign found      = |free_vec;

  // Lowest free bit
  always_comb begin
    pos = '0;
    for (int i = WORD_W - 1; i >= 0; i--) begin
      if (free_vec[i]) begin
        pos = BIT_W'(i);
      end
    end
  end

  // Status to the controller
  assign sts.clr_last   = (addr_r == LAST_ADDR);
  assign sts.in_range   = ({1'b0, idx_r} < limit);
  assign sts.words_zero = (limit == '0);
  assign sts.found      = found;
  assign sts.last_word  = ((17'(eval_addr_r) + 17'd1) >= 17'(nwords));
  assign sts.out_free   = !out_valid_r || out_ready;

  // Memory port control
  always_comb begin
    we    = 1'b0;
    waddr = addr_r;
    wdata = '0;
    if (cmd.clr_wr) begin
      we = 1'b1;
    end else if (cmd.alloc_fin && found) begin
      we    = 1'b1;
      waddr = eval_addr_r;
      wdata = rdata_r | (WORD_W'(1) << pos);
    end else if (cmd.mark_fin && (op_r == OP_MARK_USED)) begin
      we    = 1'b1;
      waddr = idx_word;
      wdata = rdata_r | idx_bit;
    end else if (cmd.mark_fin && (op_r == OP_MARK_FREE)) begin
      we    = 1'b1;
      waddr = idx_word;
      wdata = rdata_r & ~idx_bit;
    end
  end

  assign re    = cmd.scan_rd || cmd.idx_rd;
  assign raddr = cmd.idx_rd ? idx_word : addr_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  // Free count with saturation at zero and at the block count
  assign dec = (cmd.alloc_fin && found) || (cmd.mark_fin && (op_r == OP_MARK_USED));
  assign inc = cmd.mark_fin && (op_r == OP_MARK_FREE);

  always_comb begin
    free_nxt = free_r;
    if (dec && (free_r != '0)) begin
      free_nxt = free_r - COUNT_W'(1);
    end else if (inc && (free_r < limit)) begin
      free_nxt = free_r + COUNT_W'(1);
    end
  end

  // Control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      addr_r      <= '0;
      blk_count_r <= COUNT_W'(1024);
      base_r      <= '0;
      free_r      <= FREE_RST;
      out_valid_r <= 1'b0;
    end else begin
      if (cmd.load) begin
        addr_r <= '0;
      end else if (cmd.clr_wr || cmd.scan_rd) begin
        addr_r <= addr_r + AW'(1);
      end
      if (cfg_valid && (cfg_index == REG_BLOCK_COUNT)) begin
        blk_count_r <= cfg_data[COUNT_W-1:0];
      end
      if (cfg_valid && (cfg_index == REG_BASE_BLOCK)) begin
        base_r <= cfg_data;
      end
      free_r <= free_nxt;
      if (cmd.out_load) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      op_r  <= in_op;
      idx_r <= in_block_index;
    end
    if (cmd.scan_rd) begin
      eval_addr_r <= addr_r;
    end
    if (cmd.fail) begin
      res_ok_r    <= 1'b0;
      res_alloc_r <= '0;
    end else if (cmd.alloc_fin) begin
      res_ok_r    <= found;
      res_alloc_r <= found ? (17'(base_r) + 17'({eval_addr_r, pos})) : '0;
    end else if (cmd.mark_fin) begin
      res_ok_r    <= (op_r == OP_QUERY) ? ~|(rdata_r & idx_bit) : 1'b1;
      res_alloc_r <= '0;
    end
    if (cmd.out_load) begin
      out_ok_r    <= res_ok_r;
      out_alloc_r <= res_alloc_r;
      out_free_r  <= free_r;
    end
  end

  assign out_valid           = out_valid_r;
  assign out_ok              = out_ok_r;
  assign out_allocated_block = out_alloc_r;
  assign out_free_blocks     = out_free_r;

endmodule

`default_nettype wire

### design/bitmap_block_allocator.sv
// Operation: a mark reads and then rewrites the word that holds the index, a query
//   only reads it; an index out of range fails with no read. Allocate scans from
//   word 0 to the first free block or the last word in range; count zero fails.
// Throughput: one item at a time; the next beat is taken the cycle after the result
//   enters the output register. Reset: synchronous; a clearing pass writes every
//   bitmap word, one a cycle, with in_ready low; config writes still taken.
`default_nettype none

module bitmap_block_allocator #(
  parameter int unsigned MAX_BLOCKS = 1024
) (
  input  wire logic                           clk,
  input  wire logic                           rst_n,
  input  wire logic                           in_valid,
  output logic                                in_ready,
  input  wire logic [bba_pkg::OP_W-1:0]       in_op,
  input  wire logic [bba_pkg::IDX_W-1:0]      in_block_index,
  output logic                                out_valid,
  input  wire logic                           out_ready,
  output logic                                out_ok,
  output logic [bba_pkg::BLK_W-1:0]           out_allocated_block,
  output logic [bba_pkg::COUNT_W-1:0]         out_free_blocks,
  input  wire logic                           cfg_valid,
  output logic                                cfg_ready,
  input  wire logic [bba_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [bba_pkg::CFG_W-1:0]      cfg_data
);
  import bba_pkg::*;

  cmd_t cmd;
  sts_t sts;

  // Config writes are always taken
  assign cfg_ready = 1'b1;

  bba_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_op    (in_op),
    .in_ready (in_ready),
    .sts      (sts),
    .cmd      (cmd)
  );

  bba_dpath #(
    .MAX_BLOCKS (MAX_BLOCKS)
  ) u_dpath (
    .clk                 (clk),
    .rst_n               (rst_n),
    .in_op               (in_op),
    .in_block_index      (in_block_index),
    .cfg_valid           (cfg_valid),
    .cfg_index           (cfg_index),
    .cfg_data            (cfg_data),
    .out_valid           (out_valid),
    .out_ready           (out_ready),
    .out_ok              (out_ok),
    .out_allocated_block (out_allocated_block),
    .out_free_blocks     (out_free_blocks),
    .cmd                 (cmd),
    .sts                 (sts)
  );

endmodule

`default_nettype wire

### design/bba_checker.sv
// Port-level checks for the bitmap block allocator, bound to the top level.
`default_nettype none

module bba_checker (
  input wire logic        clk,
  input wire logic        rst_n,
  input wire logic        in_valid,
  input wire logic        in_ready,
  input wire logic        out_valid,
  input wire logic        out_ready,
  input wire logic        out_ok,
  input wire logic [16:0] out_allocated_block,
  input wire logic [10:0] out_free_blocks
);

  // A stalled result beat holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_ok) &&
      $stable(out_allocated_block) && $stable(out_free_blocks))
    else $error("result beat changed while stalled");

  // One item in flight: no beat taken right after a beat
  a_one_item: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !in_ready)
    else $error("input taken while an item is in work");

  // A failed result carries no block number
  a_fail_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ok |-> out_allocated_block == 17'd0)
    else $error("block number on a failed result");

  // Free count never exceeds the largest block count
  a_free_max: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_free_blocks <= 11'd1024)
    else $error("free count out of range");

endmodule

bind bitmap_block_allocator bba_checker u_bba_checker (
  .clk                 (clk),
  .rst_n               (rst_n),
  .in_valid            (in_valid),
  .in_ready            (in_ready),
  .out_valid           (out_valid),
  .out_ready           (out_ready),
  .out_ok              (out_ok),
  .out_allocated_block (out_allocated_block),
  .out_free_blocks     (out_free_blocks)
);

`default_nettype wire
